// ----- hdl/fmpll_pkg.sv -----
// ----------------------------------------------------------------------------
// fmpll_pkg: shared types and constants for the pll fm discriminator
// arctangent table, register indexes and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none
package fmpll_pkg;

    localparam int unsigned ATAN_LEN = 24;

    typedef enum logic [2:0] {
        REG_START_FREQ = 3'd0,
        REG_FREQ_LOW   = 3'd1,
        REG_FREQ_HIGH  = 3'd2,
        REG_PROP_GAIN  = 3'd3,
        REG_INT_GAIN   = 3'd4,
        REG_OUT_SCALE  = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_FREQ,
        ST_PHASE,
        ST_AFC,
        ST_AUDIO,
        ST_OUT
    } t_state;

    // atan(2^-k) in 2^32-per-turn units
    function automatic logic [31:0] atan_turns(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/fmpll_cordic.sv -----
// ----------------------------------------------------------------------------
// fmpll_cordic: iterative cordic vectoring unit
// one micro-rotation per cycle, returns the angle of (x, y)
// ----------------------------------------------------------------------------
`default_nettype none
module fmpll_cordic
    import fmpll_pkg::*;
#(
    parameter int unsigned STAGES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [15:0] i_y,
    output logic                    o_done,
    output logic [31:0]             o_angle
);

    localparam int unsigned KW = $clog2(STAGES + 1);

    // 16-bit sample scaled by 2^14 plus gain growth fits 33 bits
    logic signed [32:0] r_x, r_y, n_x, n_y;
    logic [31:0]        r_ang, n_ang;
    logic [KW-1:0]      r_k, n_k;
    logic               r_busy, n_busy;
    logic signed [32:0] xs, ys, x0, y0;

    always_comb begin
        x0 = 33'(i_x) <<< 14;
        y0 = 33'(i_y) <<< 14;
        xs = r_x >>> r_k;
        ys = r_y >>> r_k;
        n_x    = r_x;
        n_y    = r_y;
        n_ang  = r_ang;
        n_k    = r_k;
        n_busy = r_busy;
        if (i_start) begin
            n_busy = 1'b1;
            n_k    = '0;
            if (i_x < 0) begin
                n_x   = -x0;
                n_y   = -y0;
                n_ang = 32'h80000000;
            end else begin
                n_x   = x0;
                n_y   = y0;
                n_ang = '0;
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                n_x   = r_x + ys;
                n_y   = r_y - xs;
                n_ang = r_ang + atan_turns(5'(r_k));
            end else begin
                n_x   = r_x - ys;
                n_y   = r_y + xs;
                n_ang = r_ang - atan_turns(5'(r_k));
            end
            n_k = r_k + 1'b1;
            if (r_k == KW'(STAGES - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else begin
            r_busy <= n_busy;
            r_k    <= n_k;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_ang <= n_ang;
    end

    assign o_done  = r_busy && (r_k == KW'(STAGES - 1));
    assign o_angle = n_ang;

`ifndef ASSERT_OFF
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_k < KW'(STAGES))
        else $error("cordic step count out of range");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !i_start) |=> !r_busy)
        else $error("cordic did not stop after last step");
    a_idle_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_k == '0 || $past(o_done))
        else $error("cordic stopped early");
`endif

endmodule
`default_nettype wire

// ----- hdl/fm_pll_discriminator.sv -----
// ----------------------------------------------------------------------------
// fm_pll_discriminator: second-order pll fm demodulator
// cordic phase detector, clamped loop filter, nco, afc and scaled audio out
// ----------------------------------------------------------------------------
// a new beat is taken only in idle, once the last one has passed the shared
//   cordic unit and the loop-update steps (frequency, phase, afc, audio, out);
//   a result still waiting in the output register holds the sequencer in its
//   last step until the beat leaves
// reset (synchronous, active low): registers to defaults, phase, afc zero,
//   loop frequency zero, no beat pending
`default_nettype none
module fm_pll_discriminator
    import fmpll_pkg::*;
#(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_sample_i,
    input  wire logic signed [15:0] i_sample_q,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_audio_sample,
    output logic signed [31:0]      o_frequency_estimate,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // configuration registers
    logic signed [31:0] r_start_freq, r_freq_low, r_freq_high;
    logic [15:0]        r_prop_gain, r_int_gain, r_out_scale;

    // loop state
    logic [31:0]        r_phase, n_phase;
    logic signed [31:0] r_freq, n_freq;
    logic signed [31:0] r_afc, n_afc;
    logic signed [15:0] r_err, n_err;
    logic signed [15:0] r_audio, n_audio;
    logic signed [15:0] r_si, r_sq;
    logic               r_out_valid, n_out_valid;

    // output register, parts the result from the loop state
    logic signed [15:0] r_out_audio, n_out_audio;
    logic signed [31:0] r_out_freq, n_out_freq;

    t_state r_state, n_state;

    logic        cfg_wr;
    t_reg_idx    cfg_idx;
    logic        accept;
    logic        cordic_start;
    logic        cordic_done;
    logic [31:0] cordic_angle;
    logic        zero_sample;
    logic        out_free;

    // product/sum datapath: 48-bit shared loop product, 34-bit signed sum
    logic signed [47:0] prod;
    logic signed [33:0] wide_sum;
    logic signed [49:0] audio_prod;
    logic signed [40:0] audio_shift;
    logic signed [16:0] mul_b;
    logic signed [32:0] afc_diff;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);
    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign zero_sample = (r_si == '0) && (r_sq == '0);
    assign cordic_start = (r_state == ST_IDLE) && accept;
    // output register empty or its beat leaves at this edge
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        case (cfg_idx)
            REG_START_FREQ: prdata = r_start_freq;
            REG_FREQ_LOW:   prdata = r_freq_low;
            REG_FREQ_HIGH:  prdata = r_freq_high;
            REG_PROP_GAIN:  prdata = {16'h0, r_prop_gain};
            REG_INT_GAIN:   prdata = {16'h0, r_int_gain};
            REG_OUT_SCALE:  prdata = {16'h0, r_out_scale};
            default:        prdata = '0;
        endcase
    end

    fmpll_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_x     (i_sample_i),
        .i_y     (i_sample_q),
        .o_done  (cordic_done),
        .o_angle (cordic_angle)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (accept) n_state = ST_CORDIC;
            ST_CORDIC: if (cordic_done) n_state = ST_FREQ;
            ST_FREQ:   n_state = ST_PHASE;
            ST_PHASE:  n_state = ST_AFC;
            ST_AFC:    n_state = ST_AUDIO;
            ST_AUDIO:  n_state = ST_OUT;
            ST_OUT:    if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // shared multiplier: error times the gain of the current step
    always_comb begin
        mul_b = (r_state == ST_FREQ) ? {1'b0, r_int_gain} : {1'b0, r_prop_gain};
        prod  = 48'(r_err) * 48'(mul_b);
    end

    // datapath
    always_comb begin
        n_phase     = r_phase;
        n_freq      = r_freq;
        n_afc       = r_afc;
        n_err       = r_err;
        n_audio     = r_audio;
        n_out_valid = r_out_valid;
        n_out_audio = r_out_audio;
        n_out_freq  = r_out_freq;
        wide_sum    = '0;
        afc_diff    = 33'(r_freq) - 33'(r_afc);
        audio_prod  = '0;
        audio_shift = '0;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_CORDIC: begin
                if (cordic_done) begin
                    n_err = zero_sample ? 16'sd0 : 16'(cordic_angle - r_phase >> 16);
                end
            end
            ST_FREQ: begin
                // err * gain fits 33 bits; freq plus that fits 34
                wide_sum = 34'(r_freq) + 34'(prod);
                if (wide_sum < 34'(r_freq_low)) wide_sum = 34'(r_freq_low);
                if (wide_sum > 34'(r_freq_high)) wide_sum = 34'(r_freq_high);
                n_freq = 32'(wide_sum);
            end
            ST_PHASE: begin
                n_phase = r_phase + 32'(r_freq) + 32'(prod);
            end
            ST_AFC: begin
                n_afc = r_afc + 32'(afc_diff >>> 13);
            end
            ST_AUDIO: begin
                audio_prod  = 50'(afc_diff) * 50'(signed'({1'b0, r_out_scale}));
                audio_shift = 41'(audio_prod >>> 8);
                if (audio_shift > 41'sd32767) n_audio = 16'sh7FFF;
                else if (audio_shift < -41'sd32768) n_audio = 16'sh8000;
                else n_audio = 16'(audio_shift);
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_audio = r_audio;
                    n_out_freq  = r_freq;
                end
            end
            default: ;
        endcase
        // start frequency write also reloads the loop frequency
        if (cfg_wr && (cfg_idx == REG_START_FREQ)) begin
            n_freq = pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_start_freq <= '0;
            r_freq_low   <= 32'sh80000000;
            r_freq_high  <= 32'sh7FFFFFFF;
            r_prop_gain  <= 16'd6553;
            r_int_gain   <= 16'd164;
            r_out_scale  <= 16'd256;
            r_phase      <= '0;
            r_freq       <= '0;
            r_afc        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_freq      <= n_freq;
            r_afc       <= n_afc;
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_START_FREQ: r_start_freq <= pwdata;
                    REG_FREQ_LOW:  r_freq_low  <= pwdata;
                    REG_FREQ_HIGH: r_freq_high <= pwdata;
                    REG_PROP_GAIN: r_prop_gain <= pwdata[15:0];
                    REG_INT_GAIN:  r_int_gain  <= pwdata[15:0];
                    REG_OUT_SCALE: r_out_scale <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
        r_err       <= n_err;
        r_audio     <= n_audio;
        r_out_audio <= n_out_audio;
        r_out_freq  <= n_out_freq;
        if (accept) begin
            r_si <= i_sample_i;
            r_sq <= i_sample_q;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_audio_sample       = r_out_audio;
    assign o_frequency_estimate = r_out_freq;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !accept)
        else $error("beat accepted while busy");
    a_out_after_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("output valid without finished update");
    a_cordic_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_done |-> r_state == ST_CORDIC)
        else $error("cordic finished outside its phase");
`endif

endmodule
`default_nettype wire
